// ===== sv/double_ended_queue_defines.svh =====
// Assertion macros shared by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Property checked on every clock edge outside reset
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dq_pkg.sv =====
// Shared types, codes and index helpers for the double-ended queue.
package dq_pkg;

  // Store geometry
  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  // Command codes carried in the input item
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP,
    S_WAIT
  } state_t;

  // Ring slot at a given distance behind base, wrapping at DEPTH
  function automatic addr_t slot_after(addr_t base, cnt_t offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== sv/dq_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module dq_ram #(
  parameter int DEPTH_P  = 16,
  parameter int WIDTH_P  = 32,
  parameter int ADDR_W_P = $clog2(DEPTH_P)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W_P-1:0] waddr,
  input  logic [WIDTH_P-1:0]  wdata,
  input  logic [ADDR_W_P-1:0] raddr,
  output logic [WIDTH_P-1:0]  rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit values held in a ring RAM.
// Push and error results: loaded in the execute state, which then returns to idle.
// Pops: RAM read issued in execute; the wait state loads the read data as the result.
// Dump: per entry, read in the dump state and loaded in the wait state, front to back.
// Unused codes: no result. Items are taken only in idle. A held result stalls the sequencer.
// Sync active-high reset clears front, count and sequencer; RAM kept, only occupied slots read.
module double_ended_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [2:0] cmd, [34:3] value, [39:35] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] data
  output logic [1:0]  m_axis_tuser,  // [1:0] status
  output logic        m_axis_tlast   // last
);

  import dq_pkg::*;

  state_t  state, state_next;
  addr_t   front, front_next;
  cnt_t    count, count_next;
  cnt_t    idx, idx_next;
  cmd_t    cmd_r;
  data_t   value_r;

  logic    out_valid, out_valid_next;
  status_t out_status, out_status_next;
  data_t   out_data, out_data_next;
  logic    out_last, out_last_next;

  logic    ram_we;
  addr_t   ram_waddr;
  data_t   ram_rdata;
  addr_t   ram_raddr;

  logic    out_free;
  logic    is_full;
  logic    is_empty;
  logic    dump_end;

  // Ring store
  dq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || m_axis_tready;
  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);
  assign dump_end = (idx == count - CNT_W'(1));

  // Sequencer: next state, index updates, RAM control and result load.
  // A pop or dump read is issued only when the output register is free, so
  // the result can be loaded unconditionally when the read data returns.
  // Writes finish before any later item is executed: no same-entry overlap.
  always_comb begin
    state_next      = state;
    front_next      = front;
    count_next      = count;
    idx_next        = idx;
    out_valid_next  = out_valid && !m_axis_tready;
    out_status_next = out_status;
    out_data_next   = out_data;
    out_last_next   = out_last;
    ram_we          = 1'b0;
    ram_waddr       = front;
    ram_raddr       = front;

    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
          case (cmd_r)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              out_valid_next = 1'b1;
              out_last_next  = 1'b1;
              if (is_full) begin
                out_status_next = ST_FULL;
                out_data_next   = '0;
              end else begin
                ram_we = 1'b1;
                if (cmd_r == CMD_PUSH_FRONT) begin
                  ram_waddr  = (front == '0) ? ADDR_W'(DEPTH - 1) : front - ADDR_W'(1);
                  front_next = ram_waddr;
                end else begin
                  ram_waddr = slot_after(front, count);
                end
                count_next      = count + CNT_W'(1);
                out_status_next = ST_OK;
                out_data_next   = value_r;
              end
            end

            CMD_POP_FRONT, CMD_POP_BACK, CMD_DUMP: begin
              if (is_empty) begin
                out_valid_next  = 1'b1;
                out_status_next = ST_EMPTY;
                out_data_next   = '0;
                out_last_next   = 1'b1;
              end else if (cmd_r == CMD_DUMP) begin
                idx_next   = '0;
                state_next = S_DUMP;
              end else begin
                if (cmd_r == CMD_POP_FRONT) begin
                  ram_raddr  = front;
                  front_next = slot_after(front, CNT_W'(1));
                end else begin
                  ram_raddr = slot_after(front, count - CNT_W'(1));
                end
                count_next = count - CNT_W'(1);
                state_next = S_WAIT;
              end
            end

            // unused command codes give no result
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_DUMP: begin
        if (out_free) begin
          ram_raddr  = slot_after(front, idx);
          state_next = S_WAIT;
        end
      end

      S_WAIT: begin
        out_valid_next  = 1'b1;
        out_status_next = ST_OK;
        out_data_next   = ram_rdata;
        if (cmd_r == CMD_DUMP && !dump_end) begin
          out_last_next = 1'b0;
          idx_next      = idx + CNT_W'(1);
          state_next    = S_DUMP;
        end else begin
          out_last_next = 1'b1;
          state_next    = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_r   <= cmd_t'(s_axis_tdata[2:0]);
      value_r <= s_axis_tdata[34:3];
    end
    out_status <= out_status_next;
    out_data   <= out_data_next;
    out_last   <= out_last_next;
  end

  // Ports
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

endmodule

// ===== sv/dq_checker.sv =====
// Port-level checker for the double-ended queue, bound to the top level.
`include "double_ended_queue_defines.svh"

module dq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  import dq_pkg::*;

  // Reset leaves no result pending and the input side open
  `DQ_ASSERT_ALWAYS(a_reset_quiet, rst |=> (!m_axis_tvalid && s_axis_tready), "result or stall after reset")

  // An error result is a single item with zero data
  `DQ_ASSERT(a_err_item, (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tlast && m_axis_tdata == '0), "error result malformed")

  // One item at a time: the block is busy the cycle after taking an item
  `DQ_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second item taken while busy")

  // A stalled result holds
  `DQ_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)), "stalled result changed")

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

// ===== tb/deque_result_checker.sv =====
// Result checker for the double-ended queue: predicts every result and compares it.
module deque_result_checker
  import dq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [39:0] in_data,     // [2:0] cmd, [34:3] value, [39:35] zero
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_data,    // [31:0] data
  input  logic [1:0]  out_status,  // [1:0] status
  input  logic        out_last,
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    status_t     status;
    logic [31:0] data;
    logic        last;
  } dq_result_t;

  // Own copy of the ring store and its pointers
  logic [31:0] ring [DEPTH];
  addr_t       head;
  cnt_t        fill;

  dq_result_t  awaited [$];
  dq_result_t  oldest;
  int          fault_count = 0;

  task automatic report_mismatch(string what);
    fault_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  function automatic void queue_result(status_t st, logic [31:0] d, logic l);
    dq_result_t r;
    r.status = st;
    r.data   = d;
    r.last   = l;
    awaited.push_back(r);
  endfunction

  function automatic addr_t ring_slot(int offset);
    return addr_t'((int'(head) + offset) % DEPTH);
  endfunction

  // Work out the results of one accepted command and update the store
  task automatic apply_command(logic [2:0] code, logic [31:0] val);
    addr_t slot;
    case (code)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          if (code == CMD_PUSH_FRONT) begin
            head = (head == 0) ? addr_t'(DEPTH - 1) : head - 1'b1;
            slot = head;
          end else begin
            slot = ring_slot(int'(fill));
          end
          ring[slot] = val;
          fill++;
          queue_result(ST_OK, val, 1'b1);
        end
      end
      CMD_POP_FRONT: begin
        if (fill == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          queue_result(ST_OK, ring[head], 1'b1);
          head = ring_slot(1);
          fill--;
        end
      end
      CMD_POP_BACK: begin
        if (fill == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          queue_result(ST_OK, ring[ring_slot(int'(fill) - 1)], 1'b1);
          fill--;
        end
      end
      CMD_DUMP: begin
        if (fill == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(fill); i++) begin
            queue_result(ST_OK, ring[ring_slot(i)], i == int'(fill) - 1);
          end
        end
      end
      default: ;  // spare codes: no result, nothing changes
    endcase
  endtask

  // Watch both channels; results are compared before the new command is applied
  always @(posedge clk) begin
    if (rst) begin
      head = '0;
      fill = '0;
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d data %h last %0b",
                                    out_status, out_data, out_last));
        end else begin
          oldest = awaited.pop_front();
          if (out_status !== oldest.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", out_status, oldest.status));
          end
          if (out_data !== oldest.data) begin
            report_mismatch($sformatf("data %h, expected %h", out_data, oldest.data));
          end
          if (out_last !== oldest.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", out_last, oldest.last));
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_command(in_data[2:0], in_data[34:3]);
      end
    end
    outstanding <= awaited.size();
    mismatches  <= fault_count;
  end

endmodule

// ===== tb/tb_double_ended_queue.sv =====
// Top of the double-ended queue testbench: clock, reset, stimulus and verdict.
module tb_double_ended_queue;
  import dq_pkg::*;

  // Codes outside the command set, which the block must ignore
  localparam logic [2:0] SPARE_CODES [3] = '{3'd5, 3'd6, 3'd7};

  localparam int RANDOM_ITEMS    = 480;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 3000;
  localparam int DRAIN_TAIL      = 40;

  typedef enum {FILLING, DRAINING, MIXING} phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [2:0] cmd, [34:3] value, [39:35] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] data
  logic [1:0]  m_axis_tuser;        // [1:0] status
  logic        m_axis_tlast;

  int failures;
  int pending;
  int accepted_items = 0;
  int burst_left = 0;
  bit valid_dropped = 1'b1;

  always #4 clk = ~clk;

  double_ended_queue dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  deque_result_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_status (m_axis_tuser),
    .out_last   (m_axis_tlast),
    .mismatches (failures),
    .outstanding(pending)
  );

  always @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      accepted_items <= accepted_items + 1;
    end
  end

  // Offer one item, wait for it to be taken, then maybe pause between bursts
  task automatic offer(logic [2:0] code, logic [31:0] val);
    int gap;
    s_axis_tdata  <= {5'b0, val, code};
    s_axis_tvalid <= 1'b1;
    valid_dropped = 1'b0;
    do @(posedge clk); while (!s_axis_tready);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        valid_dropped = 1'b1;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: spans of full speed, fixed stall patterns and random stalls,
  // plus one long hold-off so the queue backs up and stalls its input
  initial begin
    int  mode;
    int  span;
    logic [31:0] pattern;
    bit  held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (!held && accepted_items >= 120) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode    = $urandom_range(2);
      span    = $urandom_range(16, 64);
      pattern = $urandom();
      for (int c = 0; c < span; c++) begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= pattern[c % 32];
          default: m_axis_tready <= ($urandom_range(3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: too long with no item moving on either side ends the run
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus
  initial begin
    int          made;
    int          r;
    int          phase_left;
    int          t [5];
    phase_t      phase;
    logic [2:0]  code;
    logic [31:0] val;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty queue, spare codes, extreme values, dump and drain
    offer(CMD_POP_FRONT, 32'h0);
    offer(CMD_POP_BACK, 32'hFFFF_FFFF);
    offer(CMD_DUMP, 32'h0);
    offer(SPARE_CODES[0], 32'hFFFF_FFFF);
    offer(SPARE_CODES[1], 32'h8000_0000);
    offer(SPARE_CODES[2], 32'h7FFF_FFFF);
    offer(CMD_PUSH_FRONT, 32'h8000_0000);
    offer(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    offer(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    offer(CMD_PUSH_BACK, 32'h0);
    offer(CMD_PUSH_FRONT, 32'h1);
    offer(CMD_DUMP, 32'h0);
    offer(CMD_POP_BACK, 32'h0);
    offer(CMD_POP_FRONT, 32'h0);
    offer(CMD_POP_BACK, 32'h0);
    offer(CMD_POP_FRONT, 32'h0);
    offer(CMD_POP_FRONT, 32'h0);
    offer(CMD_POP_BACK, 32'h0);

    // Random part in phases that push the queue toward full and drain it toward empty
    made       = 0;
    phase_left = 0;
    phase      = MIXING;
    while (made < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase      = phase_t'($urandom_range(2));
        phase_left = $urandom_range(20, 50);
      end
      // cumulative weights: push front, push back, pop front, pop back, dump; the rest spare codes
      case (phase)
        FILLING:  t = '{40, 78, 84, 90, 96};
        DRAINING: t = '{10, 20, 50, 80, 95};
        default:  t = '{22, 44, 66, 88, 96};
      endcase
      r = $urandom_range(99);
      if (r < t[0])      code = CMD_PUSH_FRONT;
      else if (r < t[1]) code = CMD_PUSH_BACK;
      else if (r < t[2]) code = CMD_POP_FRONT;
      else if (r < t[3]) code = CMD_POP_BACK;
      else if (r < t[4]) code = CMD_DUMP;
      else               code = SPARE_CODES[$urandom_range(2)];
      case ($urandom_range(9))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'hFFFF_FFFF;
        3:       val = 32'($urandom_range(15));
        default: val = $urandom();
      endcase
      offer(code, val);
      if (code <= CMD_DUMP) begin
        made++;
        phase_left--;
      end
    end

    // Let every awaited result arrive, then allow the block to settle
    if (!valid_dropped) begin
      s_axis_tvalid <= 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
